/* rtl/tcprx_pkg.sv */
// Shared types, widths, state codes and code conversions for the TCP receive state block.
package tcprx_pkg;

  localparam int IN_W  = 152;
  localparam int OUT_W = 104;

  // Output encoding of the connection state
  localparam logic [3:0] CODE_CLOSED     = 4'd0;
  localparam logic [3:0] CODE_LISTEN     = 4'd1;
  localparam logic [3:0] CODE_SYN_SENT   = 4'd2;
  localparam logic [3:0] CODE_SYN_RCVD   = 4'd3;
  localparam logic [3:0] CODE_ESTAB      = 4'd4;
  localparam logic [3:0] CODE_FIN_WAIT1  = 4'd5;
  localparam logic [3:0] CODE_FIN_WAIT2  = 4'd6;
  localparam logic [3:0] CODE_CLOSE_WAIT = 4'd7;
  localparam logic [3:0] CODE_CLOSING    = 4'd8;
  localparam logic [3:0] CODE_LAST_ACK   = 4'd9;
  localparam logic [3:0] CODE_TIME_WAIT  = 4'd10;
  localparam logic [3:0] CODE_MAX        = CODE_TIME_WAIT;

  typedef enum logic [10:0] {
    ST_CLOSED     = 11'b000_0000_0001,
    ST_LISTEN     = 11'b000_0000_0010,
    ST_SYN_SENT   = 11'b000_0000_0100,
    ST_SYN_RCVD   = 11'b000_0000_1000,
    ST_ESTAB      = 11'b000_0001_0000,
    ST_FIN_WAIT1  = 11'b000_0010_0000,
    ST_FIN_WAIT2  = 11'b000_0100_0000,
    ST_CLOSE_WAIT = 11'b000_1000_0000,
    ST_CLOSING    = 11'b001_0000_0000,
    ST_LAST_ACK   = 11'b010_0000_0000,
    ST_TIME_WAIT  = 11'b100_0000_0000
  } state_t;

  // Decoded item handed from front to back
  typedef struct packed {
    logic         mode;
    logic [31:0]  seq;
    logic [31:0]  ack;
    logic [15:0]  window;
    logic         syn;
    logic         ackf;
    logic         fin;
    logic         has_pay;
    logic [15:0]  acc;      // min(payload_len, rx_space)
    logic [31:0]  nln;
    logic         nst_ok;
    state_t       nst;
  } item_t;

  function automatic state_t from_code(logic [3:0] code);
    state_t s;
    unique case (code)
      CODE_CLOSED:     s = ST_CLOSED;
      CODE_LISTEN:     s = ST_LISTEN;
      CODE_SYN_SENT:   s = ST_SYN_SENT;
      CODE_SYN_RCVD:   s = ST_SYN_RCVD;
      CODE_ESTAB:      s = ST_ESTAB;
      CODE_FIN_WAIT1:  s = ST_FIN_WAIT1;
      CODE_FIN_WAIT2:  s = ST_FIN_WAIT2;
      CODE_CLOSE_WAIT: s = ST_CLOSE_WAIT;
      CODE_CLOSING:    s = ST_CLOSING;
      CODE_LAST_ACK:   s = ST_LAST_ACK;
      CODE_TIME_WAIT:  s = ST_TIME_WAIT;
      default:         s = ST_CLOSED;
    endcase
    return s;
  endfunction

  function automatic logic [3:0] to_code(state_t s);
    logic [3:0] c;
    unique case (s)
      ST_CLOSED:     c = CODE_CLOSED;
      ST_LISTEN:     c = CODE_LISTEN;
      ST_SYN_SENT:   c = CODE_SYN_SENT;
      ST_SYN_RCVD:   c = CODE_SYN_RCVD;
      ST_ESTAB:      c = CODE_ESTAB;
      ST_FIN_WAIT1:  c = CODE_FIN_WAIT1;
      ST_FIN_WAIT2:  c = CODE_FIN_WAIT2;
      ST_CLOSE_WAIT: c = CODE_CLOSE_WAIT;
      ST_CLOSING:    c = CODE_CLOSING;
      ST_LAST_ACK:   c = CODE_LAST_ACK;
      ST_TIME_WAIT:  c = CODE_TIME_WAIT;
      default:       c = CODE_CLOSED;
    endcase
    return c;
  endfunction

endpackage

/* rtl/tcprx_front.sv */
// Input stage: registers an item, unpacks it and precomputes item-local values.
module tcprx_front (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      s_tvalid,
  output logic                      s_tready,
  input  logic [tcprx_pkg::IN_W-1:0] s_tdata,
  input  logic                      s_tuser,
  output logic                      push_valid,
  output tcprx_pkg::item_t          push_item,
  input  logic                      q_full
);
  import tcprx_pkg::*;

  logic  valid;
  item_t item;
  item_t item_next;

  always_comb begin
    item_next.mode    = s_tuser;
    item_next.seq     = s_tdata[31:0];
    item_next.ack     = s_tdata[63:32];
    item_next.window  = s_tdata[79:64];
    item_next.syn     = s_tdata[80];
    item_next.ackf    = s_tdata[81];
    item_next.fin     = s_tdata[82];
    item_next.has_pay = (s_tdata[98:83] != 16'd0);
    item_next.acc     = (s_tdata[98:83] < s_tdata[114:99]) ? s_tdata[98:83] : s_tdata[114:99];
    item_next.nln     = s_tdata[146:115];
    item_next.nst_ok  = (s_tdata[150:147] <= CODE_MAX);
    item_next.nst     = from_code(s_tdata[150:147]);
  end

  assign s_tready   = !valid || !q_full;
  assign push_valid = valid && !q_full;
  assign push_item  = item;

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
    end else if (s_tready) begin
      valid <= s_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (s_tready && s_tvalid) begin
      item <= item_next;
    end
  end

endmodule

/* rtl/tcprx_queue.sv */
// Two-entry queue of decoded items between front and back.
module tcprx_queue (
  input  logic             clk,
  input  logic             rst,
  input  logic             push,
  input  tcprx_pkg::item_t push_item,
  output logic             full,
  output logic             pop_valid,
  input  logic             pop,
  output tcprx_pkg::item_t pop_item
);
  import tcprx_pkg::*;

  item_t      entry [2];
  logic       wr_ptr;
  logic       rd_ptr;
  logic [1:0] count;

  assign full      = (count == 2'd2);
  assign pop_valid = (count != 2'd0);
  assign pop_item  = entry[rd_ptr];

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count  <= 2'd0;
    end else begin
      if (push) wr_ptr <= !wr_ptr;
      if (pop)  rd_ptr <= !rd_ptr;
      case ({push, pop})
        2'b10:   count <= count + 2'd1;
        2'b01:   count <= count - 2'd1;
        default: count <= count;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (push) entry[wr_ptr] <= push_item;
  end

  a_no_overflow: assert property (@(posedge clk) disable iff (rst) !(push && full))
    else $error("queue push while full");
  a_no_underflow: assert property (@(posedge clk) disable iff (rst) !(pop && !pop_valid))
    else $error("queue pop while empty");
  a_count_range: assert property (@(posedge clk) disable iff (rst) count != 2'd3)
    else $error("queue count out of range");

endmodule

/* rtl/tcprx_back.sv */
// Connection state update and registered result output.
module tcprx_back (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        q_valid,
  input  tcprx_pkg::item_t            q_item,
  output logic                        q_pop,
  output logic                        m_tvalid,
  input  logic                        m_tready,
  output logic [tcprx_pkg::OUT_W-1:0] m_tdata
);
  import tcprx_pkg::*;

  state_t      state, state_next;
  logic [31:0] remote_next, remote_next_nx;
  logic [31:0] local_unacked, local_unacked_next;
  logic [31:0] local_next, local_next_nx;
  logic [15:0] remote_window, remote_window_next;

  logic        syn_hit, fin_hit, pay_hit, in_win;
  logic        send_ack, tw;
  logic [15:0] acc;
  logic [31:0] d_lo, d_hi, rn_base, rn_inc;

  logic        out_valid;
  logic [OUT_W-1:0] out_data;
  logic        advance;

  assign advance = !out_valid || m_tready;
  assign q_pop   = q_valid && advance;

  always_comb begin
    state_next         = state;
    remote_next_nx     = remote_next;
    local_unacked_next = local_unacked;
    local_next_nx      = local_next;
    remote_window_next = remote_window;
    syn_hit  = 1'b0;
    fin_hit  = 1'b0;
    pay_hit  = 1'b0;
    send_ack = 1'b0;
    tw       = 1'b0;
    acc      = 16'd0;
    // modulo 2^32 window check: unacked <= ack <= local_next
    d_lo     = local_unacked - q_item.ack;
    d_hi     = q_item.ack - local_next;
    in_win   = (d_lo == 32'd0 || d_lo[31]) && (d_hi == 32'd0 || d_hi[31]);
    rn_base  = remote_next;
    rn_inc   = 32'd0;
    if (q_item.mode) begin
      local_next_nx = q_item.nln;
      if (q_item.nst_ok) state_next = q_item.nst;
    end else begin
      remote_window_next = q_item.window;
      syn_hit = q_item.syn && (state == ST_SYN_SENT || state == ST_SYN_RCVD);
      if (syn_hit) begin
        state_next = ST_SYN_RCVD;
        send_ack   = 1'b1;
      end
      if (q_item.ackf) begin
        if (q_item.ack == local_next) begin
          if (state_next == ST_FIN_WAIT1) begin
            state_next = ST_FIN_WAIT2;
          end else if (state_next == ST_CLOSING) begin
            state_next = ST_TIME_WAIT;
            tw         = 1'b1;
          end
        end
        if (in_win) begin
          local_unacked_next = q_item.ack;
          if (state_next == ST_SYN_RCVD) state_next = ST_ESTAB;
        end
      end
      // a SYN sets remote_next to seq+1; FIN and payload in the same item are not counted
      fin_hit = q_item.fin && !syn_hit && (q_item.seq == remote_next);
      if (fin_hit) begin
        send_ack = 1'b1;
        if (state_next == ST_FIN_WAIT1) begin
          state_next = ST_CLOSING;
        end else if (state_next == ST_FIN_WAIT2) begin
          state_next = ST_TIME_WAIT;
          tw         = 1'b1;
        end
      end
      pay_hit = q_item.has_pay && !syn_hit && !fin_hit && (q_item.seq == remote_next);
      if (q_item.has_pay) send_ack = 1'b1;
      if (pay_hit) acc = q_item.acc;
      if (syn_hit) rn_base = q_item.seq;
      rn_inc = (syn_hit || fin_hit) ? 32'd1 : {16'd0, acc};
      remote_next_nx = rn_base + rn_inc;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= ST_CLOSED;
      remote_next   <= 32'd0;
      local_unacked <= 32'd0;
      local_next    <= 32'd0;
      remote_window <= 16'd0;
      out_valid     <= 1'b0;
    end else begin
      if (q_pop) begin
        state         <= state_next;
        remote_next   <= remote_next_nx;
        local_unacked <= local_unacked_next;
        local_next    <= local_next_nx;
        remote_window <= remote_window_next;
      end
      if (advance) out_valid <= q_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (q_pop) begin
      out_data <= {2'b00, acc, tw, send_ack, remote_window_next,
                   local_unacked_next, remote_next_nx, to_code(state_next)};
    end
  end

  assign m_tvalid = out_valid;
  assign m_tdata  = out_data;

  a_tw_state: assert property (@(posedge clk) disable iff (rst)
      out_valid && out_data[85] |-> out_data[3:0] == CODE_TIME_WAIT)
    else $error("timer start without TIME_WAIT");
  a_acc_ack: assert property (@(posedge clk) disable iff (rst)
      out_valid && out_data[101:86] != 16'd0 |-> out_data[84])
    else $error("bytes accepted without ACK");
  a_state_mirror: assert property (@(posedge clk) disable iff (rst)
      $past(q_pop) |-> out_data[3:0] == to_code(state))
    else $error("result state differs from held state");

endmodule

/* rtl/tcp_receive_connection_fsm.sv */
// Top level of the TCP receive-side connection state block.
// Data path from input accept to result valid: the input register loads on the
//   accept edge, then the queue entry, then the state update into the output
//   register.
// Throughput: one item per cycle while the output is not stalled; the state
//   registers update once per item in a loop in the back stage.
// Reset (rst, synchronous, active high): state CLOSED, all pointers and the
//   stored window zero, queue and output empty. No clearing pass.
module tcp_receive_connection_fsm (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        s_tvalid,
  output logic                        s_tready,
  // [31:0] seq_number, [63:32] ack_number, [79:64] window, [80] flag_syn,
  // [81] flag_ack, [82] flag_fin, [98:83] payload_len, [114:99] rx_space,
  // [146:115] new_local_next, [150:147] new_state, [151] zero
  input  logic [tcprx_pkg::IN_W-1:0]  s_tdata,
  // [0] mode
  input  logic                        s_tuser,
  output logic                        m_tvalid,
  input  logic                        m_tready,
  // [3:0] conn_state, [35:4] remote_next, [67:36] local_unacked,
  // [83:68] remote_window, [84] send_ack, [85] start_time_wait,
  // [101:86] accepted_bytes, [103:102] zero
  output logic [tcprx_pkg::OUT_W-1:0] m_tdata
);
  import tcprx_pkg::*;

  // front -> queue
  logic  push_valid;
  item_t push_item;
  logic  q_full;
  // queue -> back
  logic  q_valid;
  logic  q_pop;
  item_t q_item;

  // Front: takes items whenever its register is free or can drain.
  tcprx_front u_front (
    .clk        (clk),
    .rst        (rst),
    .s_tvalid   (s_tvalid),
    .s_tready   (s_tready),
    .s_tdata    (s_tdata),
    .s_tuser    (s_tuser),
    .push_valid (push_valid),
    .push_item  (push_item),
    .q_full     (q_full)
  );

  // Queue decouples front from output backpressure.
  tcprx_queue u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (push_valid),
    .push_item (push_item),
    .full      (q_full),
    .pop_valid (q_valid),
    .pop       (q_pop),
    .pop_item  (q_item)
  );

  // Back: SYN, ACK, FIN, payload and local-side update handling, one item per cycle while the output is not stalled.
  tcprx_back u_back (
    .clk      (clk),
    .rst      (rst),
    .q_valid  (q_valid),
    .q_item   (q_item),
    .q_pop    (q_pop),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
  );

endmodule
